FILE: rtl/qcv_pkg.sv
// ----------------------------------------------------------------------------
// qcv_pkg
// Shared types, codes and helpers for the quadrature counter with velocity.
// ----------------------------------------------------------------------------
package qcv_pkg;

  localparam int CHANNELS   = 2;
  localparam int COUNT_W    = 32;
  localparam int TIME_W     = 32;
  localparam int RATE_W     = 16;
  localparam int TPR_W      = 32;
  localparam int EN_W       = 2;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam int MS_PER_S          = 1000;
  localparam int PERIOD_DEFAULT_MS = 10;

  // last channel index that the tick loop visits
  localparam logic CH_LAST = 1'(CHANNELS - 1);

  typedef enum logic [2:0] {
    OP_EDGE_A = 3'd0,
    OP_EDGE_B = 3'd1,
    OP_CLEAR  = 3'd2,
    OP_TICK   = 3'd3,
    OP_READ   = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    REG_CHANNEL_ENABLE = 3'd0,
    REG_PUBLISH_ENABLE = 3'd1,
    REG_PUBLISH_RATE   = 3'd2,
    REG_TPR_CH0        = 3'd3,
    REG_TPR_CH1        = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    K_EDGE,
    K_CLEAR,
    K_TICK,
    K_READ
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic               channel;
    logic               up;
    logic [TIME_W-1:0]  now;
  } q_entry_t;

  typedef struct packed {
    logic [EN_W-1:0]                   channel_enable;
    logic                              publish_enable;
    logic [RATE_W-1:0]                 publish_rate_hz;
    logic [CHANNELS-1:0][TPR_W-1:0]    counts_per_rad;
  } cfg_t;

  typedef struct packed {
    logic [EN_W-1:0] clr_counts;
    logic            clr_last;
  } cfg_evt_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_HOLD,
    B_DECIDE,
    B_CHAN,
    B_DIV,
    B_EMIT
  } back_state_t;

  typedef enum logic [2:0] {
    D_IDLE,
    D_MULD,
    D_MULM,
    D_CMP,
    D_ITER,
    D_DONE
  } div_state_t;

  function automatic logic chan_on(logic [EN_W-1:0] en, logic ch);
    return (int'(ch) < CHANNELS) && en[ch];
  endfunction

  // any enabled channel above idx
  function automatic logic later_enabled(logic [EN_W-1:0] en, logic idx);
    logic r;
    r = 1'b0;
    for (int i = 0; i < EN_W; i++) begin
      if (i > int'(idx) && i < CHANNELS && en[i]) r = 1'b1;
    end
    return r;
  endfunction

endpackage

FILE: rtl/qcv_regs.sv
// ----------------------------------------------------------------------------
// qcv_regs
// Configuration register file behind an APB-style port.
// ----------------------------------------------------------------------------
module qcv_regs import qcv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg,
  output cfg_evt_t    evt
);

  logic     wr;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.channel_enable  <= '0;
      cfg.publish_enable  <= 1'b0;
      cfg.publish_rate_hz <= RATE_W'(100);
      for (int c = 0; c < CHANNELS; c++) cfg.counts_per_rad[c] <= TPR_W'(65536);
      evt <= '0;
    end else begin
      evt.clr_counts <= (wr && idx == REG_CHANNEL_ENABLE) ?
                        (pwdata[EN_W-1:0] ^ cfg.channel_enable) : '0;
      evt.clr_last   <= wr && (idx == REG_PUBLISH_ENABLE);
      if (wr) begin
        unique case (idx)
          REG_CHANNEL_ENABLE: cfg.channel_enable <= pwdata[EN_W-1:0];
          REG_PUBLISH_ENABLE: cfg.publish_enable <= pwdata[0];
          REG_PUBLISH_RATE: cfg.publish_rate_hz <= pwdata[RATE_W-1:0];
          REG_TPR_CH0: if (pwdata != '0) cfg.counts_per_rad[0] <= pwdata;
          REG_TPR_CH1: if (pwdata != '0) cfg.counts_per_rad[1] <= pwdata;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (idx)
      REG_CHANNEL_ENABLE: prdata = {{(32-EN_W){1'b0}}, cfg.channel_enable};
      REG_PUBLISH_ENABLE: prdata = {31'b0, cfg.publish_enable};
      REG_PUBLISH_RATE:   prdata = {{(32-RATE_W){1'b0}}, cfg.publish_rate_hz};
      REG_TPR_CH0:        prdata = cfg.counts_per_rad[0];
      REG_TPR_CH1:        prdata = cfg.counts_per_rad[1];
      default:            prdata = '0;
    endcase
  end

endmodule

FILE: rtl/qcv_front.sv
// ----------------------------------------------------------------------------
// qcv_front
// Input side: takes items, drops unused op codes, decodes count direction.
// ----------------------------------------------------------------------------
module qcv_front import qcv_pkg::*; (
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        op,
  input  logic              channel,
  input  logic              level_a,
  input  logic              level_b,
  input  logic [TIME_W-1:0] now_ms,
  input  logic              q_full,
  output logic              q_push,
  output q_entry_t          q_data
);

  logic keep;

  assign in_stall = q_full;

  always_comb begin
    keep          = 1'b1;
    q_data.kind   = K_EDGE;
    q_data.up     = 1'b0;
    unique case (op)
      OP_EDGE_A: q_data.up = (level_a == level_b);
      OP_EDGE_B: q_data.up = (level_a != level_b);
      OP_CLEAR:  q_data.kind = K_CLEAR;
      OP_TICK:   q_data.kind = K_TICK;
      OP_READ:   q_data.kind = K_READ;
      default:   keep = 1'b0;
    endcase
    q_data.channel = channel;
    q_data.now     = now_ms;
  end

  assign q_push = in_valid && !q_full && keep;

endmodule

FILE: rtl/qcv_fifo.sv
// ----------------------------------------------------------------------------
// qcv_fifo
// Short queue between the front and back parts.
// ----------------------------------------------------------------------------
module qcv_fifo import qcv_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  q_entry_t wdata,
  input  logic     pop,
  output q_entry_t rdata,
  output logic     empty,
  output logic     full
);

  q_entry_t             mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wptr;
  logic [FIFO_AW-1:0]   rptr;
  logic [FIFO_AW:0]     count;

  assign empty = (count == '0);
  assign full  = (count == (FIFO_AW+1)'(FIFO_DEPTH));
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

FILE: rtl/qcv_div.sv
// ----------------------------------------------------------------------------
// qcv_div
// Velocity unit: |delta|*1000*2^32 / (tpr*dt), restoring division one
// quotient bit per cycle, then sign and saturation to int32.
// ----------------------------------------------------------------------------
module qcv_div import qcv_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [COUNT_W-1:0] delta,
  input  logic [TPR_W-1:0]   tpr,
  input  logic [TIME_W-1:0]  dt,
  output logic               done,
  output logic [31:0]        vel
);

  localparam int M_W = COUNT_W + 10;
  localparam int D_W = TPR_W + TIME_W;

  div_state_t          state;
  div_state_t          state_next;
  logic                neg;
  logic [COUNT_W-1:0]  mag;
  logic [TPR_W-1:0]    tpr_r;
  logic [TIME_W-1:0]   dt_r;
  logic [M_W-1:0]      m;
  logic [D_W-1:0]      d;
  logic [D_W-1:0]      r;
  logic [32:0]         q;
  logic [4:0]          step;
  logic [D_W:0]        r2;
  logic                fits;

  assign r2   = {r, 1'b0};
  assign fits = (r2 >= {1'b0, d});

  always_comb begin
    state_next = state;
    unique case (state)
      D_IDLE: if (start) state_next = D_MULD;
      D_MULD: state_next = D_MULM;
      D_MULM: state_next = D_CMP;
      D_CMP:  state_next = ({{(D_W-M_W){1'b0}}, m} >= d) ? D_DONE : D_ITER;
      D_ITER: if (step == 5'd31) state_next = D_DONE;
      D_DONE: state_next = D_IDLE;
      default: state_next = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= D_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    unique case (state)
      D_IDLE: begin
        neg   <= delta[COUNT_W-1];
        mag   <= delta[COUNT_W-1] ? (COUNT_W'(0) - delta) : delta;
        tpr_r <= tpr;
        dt_r  <= dt;
      end
      D_MULD: d <= D_W'(tpr_r) * D_W'(dt_r);
      D_MULM: m <= M_W'(mag) * M_W'(MS_PER_S);
      D_CMP: begin
        // quotient of m/d nonzero: result saturates
        q    <= ({{(D_W-M_W){1'b0}}, m} < d) ? 33'd0 : 33'h1_0000_0000;
        r    <= {{(D_W-M_W){1'b0}}, m};
        step <= '0;
      end
      D_ITER: begin
        step <= step + 1'b1;
        if (fits) begin
          r <= D_W'(r2 - {1'b0, d});
          q <= {q[31:0], 1'b1};
        end else begin
          r <= r2[D_W-1:0];
          q <= {q[31:0], 1'b0};
        end
      end
      D_DONE: ;
      default: ;
    endcase
  end

  always_comb begin
    done = (state == D_DONE);
    if (neg) vel = (q[32] || q[31]) ? 32'h8000_0000 : (32'd0 - q[31:0]);
    else     vel = (q[32] || q[31]) ? 32'h7FFF_FFFF : q[31:0];
  end

endmodule

FILE: rtl/qcv_back.sv
// ----------------------------------------------------------------------------
// qcv_back
// Execution side: count state, tick rate limit, per-channel reports and the
// output register.
// ----------------------------------------------------------------------------
module qcv_back import qcv_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  cfg_evt_t            evt,
  input  q_entry_t            q_data,
  input  logic                q_empty,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_channel,
  output logic [COUNT_W-1:0]  position_count,
  output logic [31:0]         velocity_q16,
  output logic                last_of_run
);

  back_state_t          state;
  back_state_t          state_next;
  logic [COUNT_W-1:0]   counts      [CHANNELS];
  logic [COUNT_W-1:0]   prev_counts [CHANNELS];
  logic [TIME_W-1:0]    prev_time   [CHANNELS];
  logic [TIME_W-1:0]    last_report;
  logic [TIME_W-1:0]    tick_now;
  logic [TIME_W-1:0]    tick_dt;
  logic [TIME_W+RATE_W:0] hold_prod;
  logic                 ch_idx;
  logic                 res_channel;
  logic [COUNT_W-1:0]   res_count;
  logic [31:0]          res_vel;
  logic                 res_last;

  logic                 slot_free;
  logic                 out_load;
  logic                 div_start;
  logic                 div_done;
  logic [31:0]          div_vel;
  logic                 rd_ch;
  logic [COUNT_W-1:0]   rd_count;
  logic                 cur_on;
  logic                 cur_prev;
  logic                 held;

  assign slot_free = !out_valid || !out_stall;
  // one read port into the count array
  assign rd_ch     = (state == B_IDLE) ? q_data.channel : ch_idx;
  assign rd_count  = counts[rd_ch];
  assign cur_on    = chan_on(cfg.channel_enable, ch_idx);
  assign cur_prev  = (prev_time[ch_idx] != '0) && (tick_now > prev_time[ch_idx]);
  assign held      = (last_report != '0) &&
                     ((cfg.publish_rate_hz == '0) ?
                        (tick_dt < TIME_W'(PERIOD_DEFAULT_MS)) :
                        (hold_prod <= (TIME_W+RATE_W+1)'(MS_PER_S)));

  qcv_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .delta (rd_count - prev_counts[ch_idx]),
    .tpr   (cfg.counts_per_rad[ch_idx]),
    .dt    (tick_now - prev_time[ch_idx]),
    .done  (div_done),
    .vel   (div_vel)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (!q_empty) begin
          if (q_data.kind == K_READ) state_next = B_EMIT;
          else if (q_data.kind == K_TICK && cfg.publish_enable) state_next = B_HOLD;
        end
      end
      B_HOLD:   state_next = B_DECIDE;
      B_DECIDE: state_next = held ? B_IDLE : B_CHAN;
      B_CHAN: begin
        if (!cur_on) state_next = (ch_idx == CH_LAST) ? B_IDLE : B_CHAN;
        else         state_next = cur_prev ? B_DIV : B_EMIT;
      end
      B_DIV:  if (div_done) state_next = B_EMIT;
      B_EMIT: if (slot_free) state_next = res_last ? B_IDLE : B_CHAN;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = (state == B_IDLE) && !q_empty;
    div_start = (state == B_CHAN) && cur_on && cur_prev;
    out_load  = (state == B_EMIT) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        counts[c]      <= '0;
        prev_counts[c] <= '0;
        prev_time[c]   <= '0;
      end
      last_report <= '0;
      ch_idx      <= 1'b0;
    end else begin
      unique case (state)
        B_IDLE: begin
          if (q_pop && chan_on(cfg.channel_enable, q_data.channel)) begin
            if (q_data.kind == K_EDGE)
              counts[q_data.channel] <= rd_count +
                (q_data.up ? COUNT_W'(1) : {COUNT_W{1'b1}});
            else if (q_data.kind == K_CLEAR)
              counts[q_data.channel] <= '0;
          end
          tick_now <= q_data.now;
          tick_dt  <= q_data.now - last_report;
          ch_idx   <= 1'b0;
          res_channel <= q_data.channel;
          res_count   <= chan_on(cfg.channel_enable, q_data.channel) ? rd_count : '0;
          res_vel     <= '0;
          res_last    <= 1'b1;
        end
        B_HOLD: hold_prod <= ((TIME_W+RATE_W+1)'(tick_dt) + (TIME_W+RATE_W+1)'(1)) *
                             (TIME_W+RATE_W+1)'(cfg.publish_rate_hz);
        B_DECIDE: if (!held) last_report <= tick_now;
        B_CHAN: begin
          if (!cur_on) begin
            ch_idx <= ch_idx + 1'b1;
          end else begin
            res_channel         <= ch_idx;
            res_count           <= rd_count;
            res_vel             <= '0;
            res_last            <= !later_enabled(cfg.channel_enable, ch_idx);
            prev_counts[ch_idx] <= rd_count;
            prev_time[ch_idx]   <= tick_now;
          end
        end
        B_DIV: if (div_done) res_vel <= div_vel;
        B_EMIT: if (slot_free && !res_last) ch_idx <= ch_idx + 1'b1;
        default: ;
      endcase
      // register-port side effects; the user must write only while the block is idle, the block does not enforce it
      for (int c = 0; c < CHANNELS; c++) begin
        if (evt.clr_counts[c]) counts[c] <= '0;
      end
      if (evt.clr_last) last_report <= '0;
    end
  end

  // output register: a result waits here while the back part moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_channel    <= res_channel;
      position_count <= res_count;
      velocity_q16   <= res_vel;
      last_of_run    <= res_last;
    end
  end

endmodule

FILE: rtl/quadrature_counter_with_velocity.sv
// ----------------------------------------------------------------------------
// quadrature_counter_with_velocity
// Two-channel 4x quadrature counter with rate-limited count/velocity reports.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): one transfer per op: edge on A or B,
// clear, time tick or read. Items go into a two-entry queue; in_stall is
// high only while that queue is full. Unused op codes are never queued.
// Output channel (out_valid/out_stall): one transfer per result. A read gives
// one result; with publishing on, a tick that passes the rate limit gives one
// result per enabled channel, lowest first, with last_of_run on the final one.
// Flow: edge and clear ops are done in the idle state of the back part, so
// they stream at one per cycle while it is idle. A read goes from the queue
// through the idle and emit states into the output register. A tick passes
// the rate check (idle, hold, decide states), then per channel the channel
// state, the shared velocity unit when a velocity is due (start, two multiply
// steps, a compare, 32 restoring divide steps, done; no divide steps when the
// compare already saturates) and an emit into the output register.
// A stalled output holds its result; the back part stops only when it has
// a new result and the output register is still occupied.
// Reset (rst, synchronous) empties the queue and output register, clears the
// counts and history, and loads register defaults.
// ----------------------------------------------------------------------------
module quadrature_counter_with_velocity import qcv_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         op,
  input  logic               channel,
  input  logic               level_a,
  input  logic               level_b,
  input  logic [TIME_W-1:0]  now_ms,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_channel,
  output logic signed [31:0] position_count,
  output logic signed [31:0] velocity_q16,
  output logic               last_of_run
);

  cfg_t     cfg;
  cfg_evt_t evt;
  q_entry_t push_data;
  q_entry_t pop_data;
  logic     q_push;
  logic     q_pop;
  logic     q_full;
  logic     q_empty;
  logic [31:0] pos_u;
  logic [31:0] vel_u;

  qcv_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .evt     (evt)
  );

  qcv_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .op       (op),
    .channel  (channel),
    .level_a  (level_a),
    .level_b  (level_b),
    .now_ms   (now_ms),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (push_data)
  );

  qcv_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (push_data),
    .pop   (q_pop),
    .rdata (pop_data),
    .empty (q_empty),
    .full  (q_full)
  );

  qcv_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .evt            (evt),
    .q_data         (pop_data),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_channel    (out_channel),
    .position_count (pos_u),
    .velocity_q16   (vel_u),
    .last_of_run    (last_of_run)
  );

  assign position_count = signed'(pos_u);
  assign velocity_q16   = signed'(vel_u);

endmodule

FILE: rtl/qcv_checker.sv
// ----------------------------------------------------------------------------
// qcv_port_checks
// Port-level checks for the quadrature counter, bound to the top level.
// ----------------------------------------------------------------------------
module qcv_port_checks (
  input logic        clk,
  input logic        rst,
  input logic        pready,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_channel,
  input logic [31:0] position_count,
  input logic [31:0] velocity_q16,
  input logic        last_of_run
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_channel) &&
      $stable(position_count) && $stable(velocity_q16) && $stable(last_of_run))
    else $error("stalled result changed");

  // reset empties the queue and the output register
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("queue or output not cleared by reset");

  // the queue only fills after an input transfer
  a_stall_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(in_valid && !in_stall))
    else $error("in_stall rose without an input transfer");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("register port not ready");

endmodule

bind quadrature_counter_with_velocity qcv_port_checks u_qcv_port_checks (
  .clk            (clk),
  .rst            (rst),
  .pready         (pready),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_channel    (out_channel),
  .position_count (position_count),
  .velocity_q16   (velocity_q16),
  .last_of_run    (last_of_run)
);

FILE: verif/qcv_checker.sv
// ----------------------------------------------------------------------------
// qcv_checker
// Watches the config port and both item channels of the quadrature counter,
// keeps its own copy of counts, history and registers, works out the reports
// each transfer owes and compares every output transfer field by field.
// ----------------------------------------------------------------------------
module qcv_checker import qcv_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [2:0]         op,
  input  logic               channel,
  input  logic               level_a,
  input  logic               level_b,
  input  logic [TIME_W-1:0]  now_ms,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               out_channel,
  input  logic signed [31:0] position_count,
  input  logic signed [31:0] velocity_q16,
  input  logic               last_of_run,
  output int                 mismatches,
  output int                 pending,
  output int                 results_checked
);

  typedef struct {
    logic        ch;
    logic [31:0] count;
    logic [31:0] vel;
    logic        last;
  } report_t;

  report_t owed_reports[$];

  logic [EN_W-1:0]   en_bits;
  logic              pub_on;
  logic [RATE_W-1:0] rate_hz;
  logic [TPR_W-1:0]  tpr        [CHANNELS];
  logic [31:0]       count_now  [CHANNELS];
  logic [31:0]       count_then [CHANNELS];
  logic [31:0]       sample_ms  [CHANNELS];
  logic [31:0]       last_pub_ms;
  int                fail_count = 0;
  int                checked    = 0;

  task automatic clear_model();
    en_bits     = '0;
    pub_on      = 1'b0;
    rate_hz     = 16'd100;
    last_pub_ms = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      tpr[c]        = 32'h0001_0000;
      count_now[c]  = '0;
      count_then[c] = '0;
      sample_ms[c]  = '0;
    end
    owed_reports.delete();
  endtask

  // delta*1000*2^32 / (tpr*dt), truncated toward zero, clamped to int32
  function automatic logic [31:0] velocity_q16_of(logic [31:0] delta, logic [31:0] tpr_q16,
                                                  logic [31:0] dt);
    logic         neg;
    logic [63:0]  mag;
    logic [63:0]  scaled;
    logic [63:0]  denom;
    logic [127:0] quo;
    neg    = delta[31];
    mag    = {32'd0, neg ? (~delta + 32'd1) : delta};
    scaled = mag * 64'd1000;
    denom  = {32'd0, tpr_q16} * {32'd0, dt};
    if (denom == 64'd0) return 32'd0;
    if (scaled >= denom) quo = 128'h1_0000_0000;
    else quo = ({64'd0, scaled} << 32) / {64'd0, denom};
    if (neg) return (quo >= 128'h8000_0000) ? 32'h8000_0000 : (~quo[31:0] + 32'd1);
    return (quo > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo[31:0];
  endfunction

  task automatic note_mismatch(string msg);
    $display("mismatch @%0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic apply_register_write(logic [2:0] idx, logic [31:0] val);
    case (idx)
      REG_CHANNEL_ENABLE: begin
        for (int c = 0; c < CHANNELS; c++)
          if (val[c] != en_bits[c]) count_now[c] = '0;
        en_bits = val[EN_W-1:0];
      end
      REG_PUBLISH_ENABLE: begin
        pub_on      = val[0];
        last_pub_ms = '0;
      end
      REG_PUBLISH_RATE: rate_hz = val[RATE_W-1:0];
      REG_TPR_CH0:      if (val != 32'd0) tpr[0] = val;
      REG_TPR_CH1:      if (val != 32'd0) tpr[1] = val;
      default: ;
    endcase
  endtask

  task automatic publish(logic [31:0] t);
    logic [31:0] period;
    logic [31:0] since;
    logic [31:0] vel;
    int          n;
    if (!pub_on) return;
    period = (rate_hz == '0) ? 32'(PERIOD_DEFAULT_MS) : 32'(MS_PER_S) / 32'(rate_hz);
    since  = t - last_pub_ms;
    if (last_pub_ms != '0 && since < period) return;
    n = 0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (en_bits[c]) begin
        vel = '0;
        // no history yet, or time did not move forward: velocity stays zero
        if (sample_ms[c] != '0 && t > sample_ms[c])
          vel = velocity_q16_of(count_now[c] - count_then[c], tpr[c], t - sample_ms[c]);
        owed_reports.push_back('{1'(c), count_now[c], vel, 1'b0});
        count_then[c] = count_now[c];
        sample_ms[c]  = t;
        n++;
      end
    end
    if (n > 0) owed_reports[owed_reports.size()-1].last = 1'b1;
    last_pub_ms = t;
  endtask

  task automatic apply_item(logic [2:0] code, logic ch, logic a, logic b, logic [31:0] t);
    logic up;
    case (code)
      OP_EDGE_A, OP_EDGE_B: begin
        if (en_bits[ch]) begin
          up = (code == OP_EDGE_A) ? (a == b) : (a != b);
          count_now[ch] = count_now[ch] + (up ? 32'd1 : 32'hFFFF_FFFF);
        end
      end
      OP_CLEAR: if (en_bits[ch]) count_now[ch] = '0;
      OP_READ:  owed_reports.push_back('{ch, en_bits[ch] ? count_now[ch] : 32'd0, 32'd0, 1'b1});
      OP_TICK:  publish(t);
      default: ;
    endcase
  endtask

  task automatic check_report();
    report_t want;
    if (owed_reports.size() == 0) begin
      note_mismatch($sformatf("unexpected result ch%0d count %0d vel %0d", out_channel,
                              position_count, velocity_q16));
      return;
    end
    want = owed_reports.pop_front();
    checked++;
    if (out_channel !== want.ch)
      note_mismatch($sformatf("channel %0d, want %0d", out_channel, want.ch));
    if (position_count !== want.count)
      note_mismatch($sformatf("ch%0d count %0d, want %0d", want.ch, position_count,
                              $signed(want.count)));
    if (velocity_q16 !== want.vel)
      note_mismatch($sformatf("ch%0d velocity %0d, want %0d", want.ch, velocity_q16,
                              $signed(want.vel)));
    if (last_of_run !== want.last)
      note_mismatch($sformatf("ch%0d last flag %0b, want %0b", want.ch, last_of_run, want.last));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_model();
    end else begin
      if (out_valid && !out_stall) check_report();
      if (psel && penable && pwrite && pready) apply_register_write(paddr[4:2], pwdata);
      if (in_valid && !in_stall) apply_item(op, channel, level_a, level_b, now_ms);
    end
    mismatches      <= fail_count;
    pending         <= owed_reports.size();
    results_checked <= checked;
  end

endmodule

FILE: verif/tb_quadrature_counter_with_velocity.sv
// ----------------------------------------------------------------------------
// tb_quadrature_counter_with_velocity
// Drives encoder edges, clears, reads and report ticks into the counter under
// changing register settings and random flow control; the checker beside the
// block predicts and compares every report.
// ----------------------------------------------------------------------------
module tb_quadrature_counter_with_velocity;
  import qcv_pkg::*;

  localparam int DRAIN_CYCLES = 150;
  localparam int SEGMENTS     = 9;
  localparam int SEG_ITEMS    = 150;

  logic               clk = 1'b0;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [4:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid;
  logic               in_stall;
  logic [2:0]         op;
  logic               channel;
  logic               level_a;
  logic               level_b;
  logic [TIME_W-1:0]  now_ms;
  logic               out_valid;
  logic               out_stall;
  logic               out_channel;
  logic signed [31:0] position_count;
  logic signed [31:0] velocity_q16;
  logic               last_of_run;

  int mismatches;
  int pending;
  int results_checked;

  int          in_idle_pct  = 37;
  int          out_stall_pct = 54;
  int          items_sent   = 0;
  int          ticks_sent   = 0;
  int          reads_sent   = 0;
  logic [15:0] rate_now     = 16'd100;
  logic [31:0] clock_ms     = 32'd1000;
  logic [1:0]  enc_a        = '0;
  logic [1:0]  enc_b        = '0;
  logic [1:0]  spin_up      = 2'b11;

  quadrature_counter_with_velocity u_top (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall, .op, .channel, .level_a, .level_b, .now_ms,
    .out_valid, .out_stall, .out_channel, .position_count, .velocity_q16, .last_of_run
  );

  qcv_checker u_checker (
    .clk, .rst, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .in_valid, .in_stall, .op, .channel, .level_a, .level_b, .now_ms,
    .out_valid, .out_stall, .out_channel, .position_count, .velocity_q16, .last_of_run,
    .mismatches, .pending, .results_checked
  );

  initial forever #2 clk = ~clk;

  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= ($urandom_range(99) < out_stall_pct);
    end
  end

  task automatic reg_write(reg_idx_t idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    if (idx == REG_PUBLISH_RATE) rate_now = val[15:0];
  endtask

  task automatic send(logic [2:0] code, logic ch, logic a, logic b, logic [31:0] t);
    bit taken;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    op       <= code;
    channel  <= ch;
    level_a  <= a;
    level_b  <= b;
    now_ms   <= t;
    do begin
      @(posedge clk);
      taken = !in_stall;
      @(negedge clk);
    end while (!taken);
    items_sent++;
    if (code == OP_TICK) ticks_sent++;
    if (code == OP_READ) reads_sent++;
  endtask

  // quiet the input side and let queued work finish before touching registers
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_tpr();
    case ($urandom_range(5))
      0:       return 32'd1;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'd0;
      3:       return $urandom_range(4096, 1);
      4:       return 32'h0001_0000 * $urandom_range(64, 1);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_rate();
    case ($urandom_range(7))
      0:       return 32'd0;
      1:       return 32'd1;
      2:       return 32'd7;
      3:       return 32'd100;
      4:       return 32'd333;
      5:       return 32'd1000;
      6:       return 32'd65535;
      default: return $urandom_range(65535);
    endcase
  endfunction

  task automatic tick_send();
    int          r;
    logic [31:0] period;
    r      = $urandom_range(99);
    period = (rate_now == 0) ? 32'd10 : 32'd1000 / 32'(rate_now);
    if (r < 68)      clock_ms = clock_ms + period + $urandom_range(20);
    else if (r < 80) clock_ms = clock_ms + $urandom_range(period);
    else if (r < 86) clock_ms = clock_ms - $urandom_range(40, 1);
    else if (r < 92) clock_ms = $urandom();
    else if (r < 95) clock_ms = '0;
    else             clock_ms = clock_ms + $urandom_range(200000, 500);
    send(OP_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
         clock_ms);
  endtask

  task automatic random_item();
    int         r;
    logic       c;
    logic [2:0] code;
    r = $urandom_range(99);
    c = 1'($urandom_range(1));
    if (r < 55) begin
      // proper quadrature step, direction kept for a while
      if ($urandom_range(99) < 6) spin_up[c] = !spin_up[c];
      if ((enc_a[c] == enc_b[c]) == spin_up[c]) begin
        enc_b[c] = !enc_b[c];
        code     = OP_EDGE_B;
      end else begin
        enc_a[c] = !enc_a[c];
        code     = OP_EDGE_A;
      end
      send(code, c, enc_a[c], enc_b[c], $urandom());
    end else if (r < 62) begin
      code     = $urandom_range(1) ? OP_EDGE_B : OP_EDGE_A;
      enc_a[c] = 1'($urandom_range(1));
      enc_b[c] = 1'($urandom_range(1));
      send(code, c, enc_a[c], enc_b[c], $urandom());
    end else if (r < 66) begin
      send(OP_CLEAR, c, 1'($urandom_range(1)), 1'($urandom_range(1)), $urandom());
    end else if (r < 76) begin
      send(OP_READ, c, 1'($urandom_range(1)), 1'($urandom_range(1)), $urandom());
    end else if (r < 95) begin
      tick_send();
    end else begin
      send(3'($urandom_range(7, 5)), c, 1'($urandom_range(1)), 1'($urandom_range(1)),
           $urandom());
    end
  endtask

  initial begin
    rst      = 1'b1;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    in_valid = 1'b0;
    op       = OP_READ;
    channel  = 1'b0;
    level_a  = 1'b0;
    level_b  = 1'b0;
    now_ms   = '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: saturation both ways, held ticks, time wrap and zero time
    reg_write(REG_CHANNEL_ENABLE, 32'd3);
    reg_write(REG_PUBLISH_ENABLE, 32'd1);
    reg_write(REG_PUBLISH_RATE, 32'd0);
    reg_write(REG_TPR_CH0, 32'd1);
    reg_write(REG_TPR_CH1, 32'hFFFF_FFFF);
    send(OP_READ,   1'b0, 1'b0, 1'b0, 32'd0);
    send(OP_EDGE_A, 1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF);
    send(OP_EDGE_A, 1'b0, 1'b1, 1'b0, 32'd0);
    send(OP_EDGE_B, 1'b0, 1'b1, 1'b0, 32'd0);
    send(OP_EDGE_B, 1'b1, 1'b0, 1'b0, 32'd0);
    send(OP_TICK,   1'b0, 1'b0, 1'b0, 32'd100);
    send(OP_EDGE_A, 1'b0, 1'b0, 1'b0, 32'd0);
    send(OP_TICK,   1'b0, 1'b0, 1'b0, 32'd105);
    send(OP_TICK,   1'b1, 1'b1, 1'b1, 32'd110);
    send(OP_EDGE_B, 1'b0, 1'b1, 1'b1, 32'd0);
    send(OP_EDGE_B, 1'b0, 1'b0, 1'b0, 32'd0);
    send(OP_TICK,   1'b0, 1'b0, 1'b0, 32'd121);
    send(OP_TICK,   1'b0, 1'b0, 1'b0, 32'd60);
    send(OP_CLEAR,  1'b1, 1'b0, 1'b0, 32'd0);
    send(OP_READ,   1'b1, 1'b0, 1'b0, 32'd0);
    send(3'd5,      1'b0, 1'b1, 1'b1, 32'd0);
    send(3'd6,      1'b1, 1'b0, 1'b1, 32'd0);
    send(3'd7,      1'b0, 1'b1, 1'b0, 32'd0);
    send(OP_TICK,   1'b0, 1'b0, 1'b0, 32'd0);
    send(OP_TICK,   1'b0, 1'b0, 1'b0, 32'd1);
    send(OP_TICK,   1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF);
    drain();
    // zero scale is dropped; disabling a channel wipes its count
    reg_write(REG_TPR_CH0, 32'd0);
    reg_write(REG_CHANNEL_ENABLE, 32'd1);
    reg_write(REG_PUBLISH_RATE, 32'd65535);
    send(OP_EDGE_A, 1'b1, 1'b1, 1'b1, 32'd0);
    send(OP_READ,   1'b1, 1'b0, 1'b0, 32'd0);
    send(OP_TICK,   1'b0, 1'b0, 1'b0, 32'd5);
    drain();
    reg_write(REG_PUBLISH_ENABLE, 32'd0);
    reg_write(REG_CHANNEL_ENABLE, 32'd0);
    send(OP_TICK,   1'b0, 1'b0, 1'b0, 32'd7);
    send(OP_READ,   1'b0, 1'b0, 1'b0, 32'd0);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      drain();
      case (seg / 3)
        0: begin in_idle_pct = 37; out_stall_pct = 54; end
        1: begin in_idle_pct = 54; out_stall_pct = 37; end
        default: begin in_idle_pct = 0; out_stall_pct = 0; end
      endcase
      reg_write(REG_CHANNEL_ENABLE, ($urandom_range(99) < 50) ? 32'd3 : $urandom_range(3));
      reg_write(REG_PUBLISH_ENABLE, ($urandom_range(99) < 88) ? 32'd1 : 32'd0);
      reg_write(REG_PUBLISH_RATE, pick_rate());
      reg_write(REG_TPR_CH0, pick_tpr());
      reg_write(REG_TPR_CH1, pick_tpr());
      for (int i = 0; i < SEG_ITEMS; i++) random_item();
    end

    drain();
    $display("summary: %0d items (%0d ticks, %0d reads) over %0d register setups,",
             items_sent, ticks_sent, reads_sent, SEGMENTS + 3);
    $display("summary: %0d results compared", results_checked);
    if (mismatches == 0 && pending == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
